### rtl/gaussian_sample_histogram_unit_defines.svh
// Assertion macros shared by the histogram unit.
`ifndef GAUSSIAN_SAMPLE_HISTOGRAM_UNIT_DEFINES_SVH
`define GAUSSIAN_SAMPLE_HISTOGRAM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GSH_ASSERT_HOLD(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("gsh check failed");
`define GSH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gsh check failed");
`else
`define GSH_ASSERT_HOLD(lbl, clk, rstn, cond)
`define GSH_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/gsh_pkg.sv
package gsh_pkg;

    typedef struct packed {
        logic [23:0] uniform_a;
        logic [23:0] uniform_b;
    } t_in;

    typedef struct packed {
        logic signed [16:0] sample_q8;
        logic [3:0]         bin_index;
        logic               out_of_range;
        logic [15:0]        bin_count;
    } t_out;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQR,
        OP_LN,
        OP_SQRT,
        OP_X,
        OP_X2,
        OP_TM,
        OP_TD,
        OP_TC,
        OP_NM,
        OP_SM,
        OP_SAMP,
        OP_DIV,
        OP_RD,
        OP_WR
    } t_op;

    typedef enum logic [1:0] {
        REG_MEAN  = 2'd0,
        REG_SIGMA = 2'd1,
        REG_BINW  = 2'd2
    } t_reg;

    typedef struct packed {
        t_op        op;
        logic [4:0] idx;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    localparam logic [31:0] TWO_LN2_Q30  = 32'd1488522236;
    localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [15:0] MEAN_RESET   = 16'd17920;
    localparam logic [15:0] SIGMA_RESET  = 16'd5120;
    localparam logic [7:0]  BINW_RESET   = 8'd10;
    localparam logic [4:0]  SQR_STEPS    = 5'd24;
    localparam logic [4:0]  SQRT_STEPS   = 5'd22;
    localparam logic [4:0]  TERM_STEPS   = 5'd6;
    localparam logic [4:0]  DIV_STEPS    = 5'd9;

    function automatic logic [7:0] term_div(input logic [2:0] j);
        logic [7:0] d;
        case (j)
            3'd0:    d = 8'd132;
            3'd1:    d = 8'd90;
            3'd2:    d = 8'd56;
            3'd3:    d = 8'd30;
            3'd4:    d = 8'd12;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] term_recip(input logic [2:0] j);
        logic [31:0] m;
        case (j)
            3'd0:    m = 32'd32537631;
            3'd1:    m = 32'd47721858;
            3'd2:    m = 32'd76695844;
            3'd3:    m = 32'd143165576;
            3'd4:    m = 32'd357913941;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

endpackage

### rtl/gsh_ram.sv
module gsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/gsh_ctrl.sv
`include "gaussian_sample_histogram_unit_defines.svh"

module gsh_ctrl
    import gsh_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_SQR  = 15'b000000000000010,
        S_LN   = 15'b000000000000100,
        S_SQRT = 15'b000000000001000,
        S_X    = 15'b000000000010000,
        S_X2   = 15'b000000000100000,
        S_TM   = 15'b000000001000000,
        S_TD   = 15'b000000010000000,
        S_TC   = 15'b000000100000000,
        S_NM   = 15'b000001000000000,
        S_SM   = 15'b000010000000000,
        S_SAMP = 15'b000100000000000,
        S_DIV  = 15'b001000000000000,
        S_RD   = 15'b010000000000000,
        S_WR   = 15'b100000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    t_op        op;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        op      = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = S_SQR;
                    n_cnt   = '0;
                end
            end
            S_SQR: begin
                op = OP_SQR;
                if (r_cnt == SQR_STEPS - 5'd1) begin
                    n_state = S_LN;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_LN: begin
                op      = OP_LN;
                n_state = S_SQRT;
                n_cnt   = '0;
            end
            S_SQRT: begin
                op = OP_SQRT;
                if (r_cnt == SQRT_STEPS - 5'd1) begin
                    n_state = S_X;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_X: begin
                op      = OP_X;
                n_state = S_X2;
            end
            S_X2: begin
                op      = OP_X2;
                n_state = S_TM;
                n_cnt   = '0;
            end
            S_TM: begin
                op      = OP_TM;
                n_state = S_TD;
            end
            S_TD: begin
                op      = OP_TD;
                n_state = S_TC;
            end
            S_TC: begin
                op = OP_TC;
                if (r_cnt == TERM_STEPS - 5'd1) begin
                    n_state = S_NM;
                end else begin
                    n_cnt   = r_cnt + 5'd1;
                    n_state = S_TM;
                end
            end
            S_NM: begin
                op      = OP_NM;
                n_state = S_SM;
            end
            S_SM: begin
                op      = OP_SM;
                n_state = S_SAMP;
            end
            S_SAMP: begin
                op      = OP_SAMP;
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                op = OP_DIV;
                if (r_cnt == DIV_STEPS - 5'd1) begin
                    n_state = S_RD;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_RD: begin
                op      = OP_RD;
                n_state = S_WR;
            end
            S_WR: begin
                if (i_stat.out_free) begin
                    op      = OP_WR;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd.op   = op;
    assign o_cmd.idx  = r_cnt;

    `GSH_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_SQR)
    `GSH_ASSERT_HOLD(a_sqr_count, i_clk, i_rst_n, r_state != S_SQR || r_cnt < SQR_STEPS)
    `GSH_ASSERT_NEXT(a_wr_waits, i_clk, i_rst_n, r_state == S_WR && !i_stat.out_free, r_state == S_WR)

endmodule

### rtl/gsh_datapath.sv
`include "gaussian_sample_histogram_unit_defines.svh"

module gsh_datapath
    import gsh_pkg::*;
#(
    parameter int NUM_BINS   = 15,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  t_in         i_in_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data
);

    localparam int AW = $clog2(NUM_BINS);

    logic signed [15:0] r_mean;
    logic [15:0]        r_sigma;
    logic [7:0]         r_bw;
    logic [7:0]         bw_eff;

    logic [4:0]  r_p;
    logic [30:0] r_m;
    logic [23:0] r_f;
    logic [22:0] r_rp;
    logic        r_neg;
    logic [41:0] r_v;
    logic [42:0] r_res;
    logic [42:0] r_bit;
    logic [30:0] r_x;
    logic [31:0] r_x2;
    logic [30:0] r_t;
    logic [31:0] r_tv;
    logic [31:0] r_qe;
    logic [28:0] r_nm;
    logic [21:0] r_sm;
    logic signed [16:0] r_sample;
    logic        r_sneg;
    logic [8:0]  r_dn;
    logic [8:0]  r_rem;
    logic [8:0]  r_quo;
    logic        r_oor;
    logic [AW-1:0] r_addr;
    logic [NUM_BINS-1:0] r_vld;
    logic        r_out_valid;
    t_out        r_out;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    logic [23:0] a_in;
    logic [4:0]  lead;
    logic [54:0] m_shift;
    logic [1:0]  quad;
    logic [21:0] rem_b;
    logic [31:0] mm;
    logic [28:0] lval;
    logic [43:0] trial;
    logic        sq_ge;
    logic [7:0]  dcon;
    logic [39:0] qd;
    logic [39:0] trem;
    logic [31:0] qfix;
    logic [52:0] nm_sum;
    logic [45:0] sm_sum;
    logic signed [23:0] s_wide;
    logic signed [16:0] s_sat;
    logic [16:0] s_mag;
    logic [8:0]  dv_shift;
    logic        dv_ge;
    logic        oor;
    logic [COUNT_BITS-1:0] rdata;
    logic [COUNT_BITS-1:0] cnt_old;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [31:0] cnt_wide;
    logic        ram_we;
    logic        ram_re;
    logic        out_free;

    assign bw_eff = (r_bw == 8'd0) ? 8'd1 : r_bw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= MEAN_RESET;
            r_sigma <= SIGMA_RESET;
            r_bw    <= BINW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MEAN:  r_mean  <= i_cfg_data;
                REG_SIGMA: r_sigma <= i_cfg_data;
                REG_BINW:  r_bw    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        a_in = (i_in_data.uniform_a == 24'd0) ? 24'd1 : i_in_data.uniform_a;
        lead = '0;
        for (int k = 0; k < 24; k++) begin
            if (a_in[k]) begin
                lead = 5'(k);
            end
        end
        m_shift = {31'd0, a_in} << (5'd30 - lead);
        quad    = i_in_data.uniform_b[23:22];
        rem_b   = i_in_data.uniform_b[21:0];
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_SQR: begin
                mul_a = {1'b0, r_m};
                mul_b = {1'b0, r_m};
            end
            OP_LN: begin
                mul_a = {3'd0, lval};
                mul_b = TWO_LN2_Q30;
            end
            OP_X: begin
                mul_a = {9'd0, r_rp};
                mul_b = HALF_PI_Q30;
            end
            OP_X2: begin
                mul_a = {1'b0, r_x};
                mul_b = {1'b0, r_x};
            end
            OP_TM: begin
                mul_a = r_x2;
                mul_b = {1'b0, r_t};
            end
            OP_TD: begin
                mul_a = r_tv;
                mul_b = term_recip(i_cmd.idx[2:0]);
            end
            OP_NM: begin
                mul_a = {11'd0, r_res[20:0]};
                mul_b = {1'b0, r_t};
            end
            OP_SM: begin
                mul_a = {16'd0, r_sigma};
                mul_b = {3'd0, r_nm};
            end
            default: begin
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb begin
        mm     = prod[61:30];
        lval   = {5'(5'd24 - r_p), 24'd0} - {5'd0, r_f};
        trial  = {1'b0, r_res} + {1'b0, r_bit};
        sq_ge  = {2'b0, r_v} >= trial;
        dcon   = term_div(i_cmd.idx[2:0]);
        qd     = r_qe * dcon;
        trem   = {8'd0, r_tv} - qd;
        qfix   = r_qe + ((trem >= {32'd0, dcon}) ? 32'd1 : 32'd0);
        nm_sum = prod[52:0] + 53'h80_0000;
        sm_sum = prod[45:0] + 46'h80_0000;
        if (r_neg) begin
            s_wide = 24'(r_mean) - $signed({2'b0, r_sm});
        end else begin
            s_wide = 24'(r_mean) + $signed({2'b0, r_sm});
        end
        if (s_wide > 24'sd65535) begin
            s_sat = 17'sd65535;
        end else if (s_wide < -24'sd65536) begin
            s_sat = -17'sd65536;
        end else begin
            s_sat = s_wide[16:0];
        end
        s_mag    = s_sat[16] ? 17'(-s_sat) : s_sat;
        dv_shift = {r_rem[7:0], r_dn[8]};
        dv_ge    = dv_shift >= {1'b0, bw_eff};
        oor      = (r_sneg && (r_quo != 9'd0)) || (r_quo >= 9'(NUM_BINS));
        cnt_old  = r_vld[r_addr] ? rdata : '0;
        cnt_new  = (&cnt_old) ? cnt_old : cnt_old + 1'b1;
        cnt_wide = 32'(cnt_new);
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_p   <= lead;
                r_m   <= m_shift[30:0];
                r_f   <= '0;
                r_rp  <= quad[0] ? (23'h40_0000 - {1'b0, rem_b}) : {1'b0, rem_b};
                r_neg <= quad[0] ^ quad[1];
            end
            OP_SQR: begin
                r_m <= mm[31] ? mm[31:1] : mm[30:0];
                r_f <= {r_f[22:0], mm[31]};
            end
            OP_LN: begin
                r_v   <= {prod[59:30], 12'd0};
                r_res <= '0;
                r_bit <= 43'h1 << 42;
            end
            OP_SQRT: begin
                if (sq_ge) begin
                    r_v   <= r_v - trial[41:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_X: begin
                r_x <= prod[52:22];
            end
            OP_X2: begin
                r_x2 <= prod[61:30];
                r_t  <= Q30_ONE;
            end
            OP_TM: begin
                r_tv <= prod[61:30];
            end
            OP_TD: begin
                r_qe <= prod[63:32];
            end
            OP_TC: begin
                r_t <= (qfix >= {1'b0, Q30_ONE}) ? 31'd0 : Q30_ONE - qfix[30:0];
            end
            OP_NM: begin
                r_nm <= nm_sum[52:24];
            end
            OP_SM: begin
                r_sm <= sm_sum[45:24];
            end
            OP_SAMP: begin
                r_sample <= s_sat;
                r_sneg   <= s_sat[16];
                r_dn     <= s_mag[16:8];
                r_rem    <= '0;
                r_quo    <= '0;
            end
            OP_DIV: begin
                r_rem <= dv_ge ? dv_shift - {1'b0, bw_eff} : dv_shift;
                r_quo <= {r_quo[7:0], dv_ge};
                r_dn  <= r_dn << 1;
            end
            OP_RD: begin
                r_oor  <= oor;
                r_addr <= r_quo[AW-1:0];
            end
            OP_WR: begin
                r_out.sample_q8    <= r_sample;
                r_out.bin_index    <= r_oor ? 4'd0 : r_quo[3:0];
                r_out.out_of_range <= r_oor;
                r_out.bin_count    <= r_oor ? 16'd0 : cnt_wide[15:0];
            end
            default: begin
            end
        endcase
    end

    assign ram_re = (i_cmd.op == OP_RD);
    assign ram_we = (i_cmd.op == OP_WR) && !r_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ram_we) begin
            r_vld[r_addr] <= 1'b1;
        end
    end

    gsh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (cnt_new),
        .i_re    (ram_re),
        .i_raddr (r_quo[AW-1:0]),
        .o_rdata (rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_WR) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    `GSH_ASSERT_NEXT(a_wr_shows, i_clk, i_rst_n, i_cmd.op == OP_WR, r_out_valid)
    `GSH_ASSERT_HOLD(a_oor_zero, i_clk, i_rst_n, !(r_out_valid && r_out.out_of_range) || (r_out.bin_count == 16'd0 && r_out.bin_index == 4'd0))
    `GSH_ASSERT_HOLD(a_div_rem, i_clk, i_rst_n, i_cmd.op != OP_DIV || r_rem < {1'b0, bw_eff})

endmodule

### rtl/gaussian_sample_histogram_unit.sv
// One item is processed at a time: o_in_stall stays high until the result of the
// last item is written to the output register. A single shared multiplier runs
// the 24 log squarings and the cosine terms; the 22-step square root and the
// 9-step bin divider do not use it. Reset is synchronous and active low; it restores the
// register defaults and marks all histogram counters as zero at once.
module gaussian_sample_histogram_unit
    import gsh_pkg::*;
#(
    parameter int NUM_BINS   = 15,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    gsh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gsh_datapath #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### dv/gaussian_sample_histogram_unit_tb.sv
`timescale 1ns / 1ps

module gaussian_sample_histogram_unit_tb;
    import gsh_pkg::*;

    localparam int BINS = 15;
    localparam int CNT_MAX = 65535;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    logic signed [15:0] mean_reg;
    logic [15:0]        sigma_reg;
    logic [7:0]         binw_reg;
    logic [15:0]        hist[BINS];
    t_out               pending_samples[$];
    int                 errors;
    bit                 steady;

    gaussian_sample_histogram_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned cos_mag(input logic [22:0] r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned q;
        x = (64'(r) * 64'(HALF_PI_Q30)) >> 22;
        x2 = (x * x) >> 30;
        t = 64'(Q30_ONE);
        for (int j = 0; j < 6; j++) begin
            q = ((x2 * t) >> 30) / 64'(term_div(3'(j)));
            t = (q >= 64'(Q30_ONE)) ? 64'd0 : 64'(Q30_ONE) - q;
        end
        return t;
    endfunction

    function automatic longint unsigned minus_log2(input logic [23:0] a);
        int p;
        longint unsigned m;
        longint unsigned f;
        p = 23;
        f = 0;
        while (p > 0 && a[p] == 1'b0) p--;
        m = 64'(a) << (30 - p);
        for (int i = 1; i <= 24; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'(Q30_ONE) << 1)) begin
                m >>= 1;
                f |= 64'd1 << (24 - i);
            end
        end
        return (64'(24 - p) << 24) - f;
    endfunction

    function automatic t_out gaussian_bin(input t_in item);
        t_out res;
        logic [23:0] a;
        logic [1:0] quad;
        logic [21:0] r;
        longint unsigned rq, s, c, nm, sm;
        longint samp, rank, bw;
        a = (item.uniform_a == 0) ? 24'd1 : item.uniform_a;
        rq = (minus_log2(a) * 64'(TWO_LN2_Q30)) >> 30;
        s = root_floor(rq << 12);
        quad = item.uniform_b[23:22];
        r = item.uniform_b[21:0];
        if (quad == 2'd1 || quad == 2'd3) c = cos_mag(23'h400000 - 23'(r));
        else c = cos_mag(23'(r));
        nm = (s * c + (64'd1 << 23)) >> 24;
        sm = (64'(sigma_reg) * nm + (64'd1 << 23)) >> 24;
        samp = (quad == 2'd1 || quad == 2'd2) ? longint'(mean_reg) - longint'(sm)
                                              : longint'(mean_reg) + longint'(sm);
        if (samp > 65535) samp = 65535;
        if (samp < -65536) samp = -65536;
        bw = (binw_reg == 0) ? 1 : longint'(binw_reg);
        rank = samp / (bw * 256);
        res.sample_q8 = 17'(samp);
        if (rank < 0 || rank >= BINS) begin
            res.bin_index = 4'd0;
            res.out_of_range = 1'b1;
            res.bin_count = 16'd0;
        end else begin
            if (hist[rank] < CNT_MAX) hist[rank] = hist[rank] + 16'd1;
            res.bin_index = 4'(rank);
            res.out_of_range = 1'b0;
            res.bin_count = hist[rank];
        end
        return res;
    endfunction

    function automatic int gap_len();
        if (steady) return 0;
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected item %p", $time, o_out_data);
                errors++;
            end else begin
                want = pending_samples.pop_front();
                if (o_out_data.sample_q8 !== want.sample_q8) begin
                    $display("%0t: sample_q8 expected %0d actual %0d", $time,
                             want.sample_q8, o_out_data.sample_q8);
                    errors++;
                end
                if (o_out_data.bin_index !== want.bin_index) begin
                    $display("%0t: bin_index expected %0d actual %0d", $time,
                             want.bin_index, o_out_data.bin_index);
                    errors++;
                end
                if (o_out_data.out_of_range !== want.out_of_range) begin
                    $display("%0t: out_of_range expected %0b actual %0b", $time,
                             want.out_of_range, o_out_data.out_of_range);
                    errors++;
                end
                if (o_out_data.bin_count !== want.bin_count) begin
                    $display("%0t: bin_count expected %0d actual %0d", $time,
                             want.bin_count, o_out_data.bin_count);
                    errors++;
                end
            end
        end
        if (steady) i_out_stall <= 1'b0;
        else if (i_out_stall) i_out_stall <= ($urandom_range(0, 9) < 6);
        else i_out_stall <= ($urandom_range(0, 99) < 8);
    end

    task automatic send_sample(input logic [23:0] a, input logic [23:0] b);
        t_in item;
        int gap;
        item.uniform_a = a;
        item.uniform_b = b;
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_samples.push_back(gaussian_bin(item));
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MEAN:  mean_reg = value;
            REG_SIGMA: sigma_reg = value;
            REG_BINW:  binw_reg = value[7:0];
            default: ;
        endcase
    endtask

    task automatic test_defaults();
        send_sample(24'd0, 24'd0);
        send_sample(24'hFFFFFF, 24'hFFFFFF);
        send_sample(24'd1, 24'h3FFFFF);
        send_sample(24'h800000, 24'h400000);
        send_sample(24'h000123, 24'h7FFFFF);
        send_sample(24'h555555, 24'h800000);
        send_sample(24'hAAAAAA, 24'hC00000);
        send_sample(24'h000001, 24'hBFFFFF);
    endtask

    task automatic test_extremes();
        write_reg(REG_UNUSED, 16'hFFFF);
        send_sample(24'h000010, 24'h000000);
        write_reg(REG_SIGMA, 16'hFFFF);
        write_reg(REG_MEAN, 16'h7FFF);
        send_sample(24'd0, 24'd0);
        send_sample(24'd0, 24'h800000);
        write_reg(REG_MEAN, 16'h8000);
        send_sample(24'd0, 24'h800000);
        send_sample(24'd2, 24'h000000);
        write_reg(REG_SIGMA, 16'd0);
        write_reg(REG_BINW, 16'd0);
        send_sample(24'h123456, 24'h654321);
        write_reg(REG_MEAN, 16'd3839);
        send_sample(24'hFFFFFF, 24'h000000);
        write_reg(REG_MEAN, 16'hFF01);
        send_sample(24'h400000, 24'h400000);
        write_reg(REG_BINW, 16'd255);
        write_reg(REG_MEAN, 16'h7FFF);
        send_sample(24'h7FFFFF, 24'h200000);
        write_reg(REG_MEAN, 16'd0);
        send_sample(24'h0F0F0F, 24'hF0F0F0);
    endtask

    task automatic random_phase(input int count, input logic [15:0] mean,
                                input logic [15:0] sigma, input logic [7:0] bw);
        logic [23:0] a;
        write_reg(REG_MEAN, mean);
        write_reg(REG_SIGMA, sigma);
        write_reg(REG_BINW, {8'd0, bw});
        for (int i = 0; i < count; i++) begin
            steady = (i % 100) >= 80;
            a = 24'($urandom_range(0, 24'hFFFFFF));
            if ($urandom_range(0, 7) == 0) a = a >> $urandom_range(1, 23);
            send_sample(a, 24'($urandom_range(0, 24'hFFFFFF)));
        end
        steady = 1'b0;
    endtask

    task automatic test_random();
        random_phase(500, 16'd17920, 16'd5120, 8'd10);
        random_phase(150, 16'd2000, 16'd4000, 8'd1);
        random_phase(150, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)));
        random_phase(150, 16'h8000, 16'hFFFF, 8'd255);
        random_phase(150, 16'd12800, 16'd40000, 8'd7);
    endtask

    initial begin
        errors = 0;
        steady = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_MEAN;
        i_cfg_data = '0;
        mean_reg = MEAN_RESET;
        sigma_reg = SIGMA_RESET;
        binw_reg = BINW_RESET;
        foreach (hist[k]) hist[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_extremes();
        test_random();
        wait_idle();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
